FILE: rtl/dfu_pkg.sv
package dfu_pkg;

   // field widths
   localparam int OP_WIDTH       = 3;
   localparam int LEN_WIDTH      = 16;
   localparam int KIND_WIDTH     = 2;
   localparam int STATE_WIDTH    = 4;
   localparam int SIZE_WIDTH     = 25;
   localparam int ADDR_WIDTH     = 24;
   localparam int WIN_LEN_WIDTH  = 13;

   // largest accepted data block in bytes
   localparam int MAX_BLOCK = 256;

   typedef logic [OP_WIDTH-1:0]      op_type;
   typedef logic [LEN_WIDTH-1:0]     len_type;
   typedef logic [KIND_WIDTH-1:0]    kind_type;
   typedef logic [STATE_WIDTH-1:0]   state_type;
   typedef logic [SIZE_WIDTH-1:0]    prog_space_type;
   typedef logic [ADDR_WIDTH-1:0]    addr_type;
   typedef logic [WIN_LEN_WIDTH-1:0] win_len_type;

   // command opcodes
   localparam op_type OP_DNLOAD    = 3'd0;
   localparam op_type OP_UPLOAD    = 3'd1;
   localparam op_type OP_GETSTATUS = 3'd2;
   localparam op_type OP_CLRSTATUS = 3'd3;
   localparam op_type OP_GETSTATE  = 3'd4;
   localparam op_type OP_ABORT     = 3'd5;
   localparam op_type OP_GETINFO   = 3'd6;

   // update states
   localparam state_type ST_APP_IDLE   = 4'd0;
   localparam state_type ST_APP_DETACH = 4'd1;
   localparam state_type ST_IDLE       = 4'd2;
   localparam state_type ST_DN_SYNC    = 4'd3;
   localparam state_type ST_DN_BUSY    = 4'd4;
   localparam state_type ST_DN_IDLE    = 4'd5;
   localparam state_type ST_MAN_SYNC   = 4'd6;
   localparam state_type ST_MANIFEST   = 4'd7;
   localparam state_type ST_MAN_WAIT   = 4'd8;
   localparam state_type ST_UP_IDLE    = 4'd9;
   localparam state_type ST_ERROR      = 4'd10;

   // reply kinds
   localparam kind_type KIND_NONE   = 2'd0;
   localparam kind_type KIND_STATUS = 2'd1;
   localparam kind_type KIND_INFO   = 2'd2;
   localparam kind_type KIND_UPLOAD = 2'd3;

   // status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // persistent machine context
   typedef struct packed {
      state_type      update_state;
      logic           status_flag;
      prog_space_type program_address;
   } ctx_type;

   // one result transaction
   typedef struct packed {
      kind_type    reply_kind;
      state_type   machine_state;
      logic        status_code;
      addr_type    window_address;
      win_len_type window_length;
      logic        boot_request;
   } result_type;

endpackage

FILE: rtl/dfu_if.sv
interface dfu_req_if;
   logic             valid;
   logic             ready;
   dfu_pkg::op_type  operation;
   dfu_pkg::len_type length;

   modport source (output valid, output operation, output length, input ready);
   modport sink   (input valid, input operation, input length, output ready);
endinterface

interface dfu_rsp_if;
   logic                 valid;
   logic                 ready;
   dfu_pkg::kind_type    reply_kind;
   dfu_pkg::state_type   machine_state;
   logic                 status_code;
   dfu_pkg::addr_type    window_address;
   dfu_pkg::win_len_type window_length;
   logic                 boot_request;

   modport source (output valid, output reply_kind, output machine_state,
                   output status_code, output window_address,
                   output window_length, output boot_request, input ready);
   modport sink   (input valid, input reply_kind, input machine_state,
                   input status_code, input window_address,
                   input window_length, input boot_request, output ready);
endinterface

FILE: rtl/dfu_step.sv
module dfu_step (
   input  dfu_pkg::op_type         operation,
   input  dfu_pkg::len_type        length,
   input  dfu_pkg::prog_space_type prog_space,
   input  dfu_pkg::ctx_type        ctx,
   output dfu_pkg::ctx_type        ctx_next,
   output dfu_pkg::result_type     result
);
   import dfu_pkg::*;

   prog_space_type        base_address;
   logic [SIZE_WIDTH:0]   end_address;
   logic                  block_bad;
   logic                  len_zero;
   logic                  start_dn;
   logic                  start_up;

   // block bounds check, address restarts from zero in dfu idle
   always_comb begin
      base_address = (ctx.update_state == ST_IDLE) ? '0 : ctx.program_address;
      end_address  = {1'b0, base_address} + (SIZE_WIDTH+1)'(length);
      block_bad    = (length > LEN_WIDTH'(MAX_BLOCK)) ||
                     (end_address > {1'b0, prog_space});
      len_zero     = (length == '0);
   end

   // state decode
   always_comb begin
      ctx_next = ctx;
      result   = '0;
      start_dn = 1'b0;
      start_up = 1'b0;

      if (operation == OP_GETSTATE) begin
         result.reply_kind = KIND_STATUS;
      end else if (operation == OP_ABORT) begin
         ctx_next.update_state = ST_IDLE;
         ctx_next.status_flag  = STATUS_OK;
      end else begin
         case (ctx.update_state)
            ST_IDLE: begin
               if (operation == OP_DNLOAD) begin
                  ctx_next.program_address = '0;
                  start_dn = 1'b1;
               end else if (operation == OP_UPLOAD) begin
                  ctx_next.program_address = '0;
                  start_up = 1'b1;
               end else if (operation == OP_GETSTATUS) begin
                  result.reply_kind = KIND_STATUS;
               end else if (operation == OP_GETINFO) begin
                  result.reply_kind    = KIND_INFO;
                  ctx_next.status_flag = STATUS_OK;
               end else begin
                  ctx_next.update_state = ST_ERROR;
               end
            end
            ST_DN_SYNC: begin
               if (operation == OP_GETSTATUS) begin
                  ctx_next.update_state = ST_DN_IDLE;
                  result.reply_kind     = KIND_STATUS;
               end else begin
                  ctx_next.update_state = ST_ERROR;
               end
            end
            ST_DN_IDLE: begin
               if (operation == OP_GETSTATUS) begin
                  result.reply_kind = KIND_STATUS;
               end else if (operation == OP_DNLOAD) begin
                  start_dn = 1'b1;
               end else begin
                  ctx_next.update_state = ST_ERROR;
               end
            end
            ST_MAN_SYNC: begin
               if (operation == OP_GETSTATUS) begin
                  ctx_next.update_state = ST_MANIFEST;
                  result.reply_kind     = KIND_STATUS;
                  result.boot_request   = 1'b1;
               end else begin
                  ctx_next.update_state = ST_ERROR;
               end
            end
            ST_UP_IDLE: begin
               if (operation == OP_GETSTATUS) begin
                  result.reply_kind = KIND_STATUS;
               end else if (operation == OP_UPLOAD) begin
                  start_up = 1'b1;
               end else begin
                  ctx_next.update_state = ST_ERROR;
               end
            end
            ST_ERROR: begin
               // leaving error keeps the status as it is
               if (operation == OP_CLRSTATUS) begin
                  ctx_next.update_state = ST_IDLE;
               end
            end
            default: begin
               ctx_next.update_state = ST_ERROR;
            end
         endcase
      end

      // block transfers
      if (start_dn || start_up) begin
         if (block_bad) begin
            ctx_next.status_flag  = STATUS_ERR;
            ctx_next.update_state = ST_ERROR;
         end else if (len_zero) begin
            if (start_dn) begin
               ctx_next.update_state = ST_MAN_SYNC;
            end else begin
               ctx_next.status_flag  = STATUS_OK;
               ctx_next.update_state = ST_IDLE;
            end
         end else begin
            result.window_address    = base_address[ADDR_WIDTH-1:0];
            result.window_length     = length[WIN_LEN_WIDTH-1:0];
            ctx_next.program_address = end_address[SIZE_WIDTH-1:0];
            ctx_next.status_flag     = STATUS_OK;
            if (start_dn) begin
               ctx_next.update_state = ST_DN_SYNC;
            end else begin
               ctx_next.update_state = ST_UP_IDLE;
               result.reply_kind     = KIND_UPLOAD;
            end
         end
      end

      result.machine_state = ctx_next.update_state;
      result.status_code   = ctx_next.status_flag;
   end

endmodule

FILE: rtl/dfu_command_state_machine.sv
// A command transaction is accepted into the command register, passes through the
// state decode and is held in the result register until the response side takes it.
// Throughput: one command per cycle while the response side takes each result, set by
// the combinational state decode between the command register and the result register.
// Reset (synchronous, active high): state dfu idle, status ok, program address 0,
// space limit 0, both pipeline registers empty.
module dfu_command_state_machine (
   input  logic                    clock,
   input  logic                    reset,
   dfu_req_if.sink                 req,
   dfu_rsp_if.source               rsp,
   input  logic                    csr_write_enable,
   input  dfu_pkg::prog_space_type csr_write_data
);
   import dfu_pkg::*;

   logic           cmd_valid_ff;
   op_type         cmd_op_ff;
   len_type        cmd_len_ff;
   logic           res_valid_ff;
   logic           res_valid_in;
   result_type     res_ff;
   result_type     res_in;
   ctx_type        ctx_ff;
   ctx_type        ctx_in;
   prog_space_type prog_space_ff;
   logic           advance;

   // pipeline flow
   assign advance   = cmd_valid_ff && (!res_valid_ff || rsp.ready);
   assign req.ready = !cmd_valid_ff || advance;

   // command register
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req.ready) begin
         cmd_valid_ff <= req.valid;
      end
      if (req.valid && req.ready) begin
         cmd_op_ff  <= req.operation;
         cmd_len_ff <= req.length;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         prog_space_ff <= '0;
      end else if (csr_write_enable) begin
         prog_space_ff <= csr_write_data;
      end
   end

   dfu_step u_step (
      .operation  (cmd_op_ff),
      .length     (cmd_len_ff),
      .prog_space (prog_space_ff),
      .ctx        (ctx_ff),
      .ctx_next   (ctx_in),
      .result     (res_in)
   );

   // machine context
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.update_state    <= ST_IDLE;
         ctx_ff.status_flag     <= STATUS_OK;
         ctx_ff.program_address <= '0;
      end else if (advance) begin
         ctx_ff <= ctx_in;
      end
   end

   // result register
   always_comb begin
      res_valid_in = res_valid_ff && !rsp.ready;
      if (advance) begin
         res_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid          = res_valid_ff;
   assign rsp.reply_kind     = res_ff.reply_kind;
   assign rsp.machine_state  = res_ff.machine_state;
   assign rsp.status_code    = res_ff.status_code;
   assign rsp.window_address = res_ff.window_address;
   assign rsp.window_length  = res_ff.window_length;
   assign rsp.boot_request   = res_ff.boot_request;

endmodule
